/* design/worker_utilization_accounting_core_assert.svh */
// ----------------------------------------------------------------------------
// Worker utilization accounting assertion macros
// Property wrappers used by the core; they compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef WORKER_UTILIZATION_ACCOUNTING_CORE_ASSERT_SVH
`define WORKER_UTILIZATION_ACCOUNTING_CORE_ASSERT_SVH

`ifndef SYNTH
`define WUAC_ASSERT_IMP(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("wuac assertion failed");
`define WUAC_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("wuac assertion failed");
`else
`define WUAC_ASSERT_IMP(label, clk, rst, cond, expr)
`define WUAC_ASSERT_NEXT(label, clk, rst, cond, expr)
`endif

`endif

/* design/wuac_pkg.sv */
// ----------------------------------------------------------------------------
// Worker utilization accounting package
// Fixed field widths, queue depth and event codes shared by the core.
// ----------------------------------------------------------------------------
package wuac_pkg;

   localparam int OUT_TIME_W  = 64;
   localparam int OUT_COUNT_W = 16;
   localparam int WORKER_W    = 11;
   localparam int OP_W        = 2;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [OP_W-1:0] {
      OP_READY = 2'd0,
      OP_START = 2'd1,
      OP_END   = 2'd2
   } op_type;

endpackage

/* design/wuac_fifo.sv */
// ----------------------------------------------------------------------------
// Worker utilization accounting queue
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module wuac_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == (AW+1)'(DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

/* design/wuac_front.sv */
// ----------------------------------------------------------------------------
// Worker utilization accounting front end
// Accepts events, computes the interval and the worker split, updates counts.
// ----------------------------------------------------------------------------
module wuac_front #(
   parameter int COUNT_WIDTH = 16,
   parameter int TIME_WIDTH  = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   input  logic [wuac_pkg::WORKER_W-1:0]     csr_data,
   input  logic                              req_push,
   input  logic [wuac_pkg::OUT_TIME_W-1:0]   req_event_time,
   input  logic [wuac_pkg::OP_W-1:0]         req_operation,
   input  logic                              q_full,
   output logic                              q_push,
   output logic [TIME_WIDTH-1:0]             q_dt,
   output logic [COUNT_WIDTH-1:0]            q_run_old,
   output logic [wuac_pkg::WORKER_W-1:0]     q_delay,
   output logic [wuac_pkg::WORKER_W-1:0]     q_idle,
   output logic [COUNT_WIDTH-1:0]            q_run_new,
   output logic [COUNT_WIDTH-1:0]            q_rdy_new,
   output logic                              q_over,
   output logic                              q_err
);
   import wuac_pkg::*;

   localparam int SUM_W = ((COUNT_WIDTH > WORKER_W) ? COUNT_WIDTH : WORKER_W) + 1;

   logic [WORKER_W-1:0]    worker_ff, worker_in;
   logic [TIME_WIDTH-1:0]  last_time_ff, last_time_in;
   logic [COUNT_WIDTH-1:0] run_ff, run_in;
   logic [COUNT_WIDTH-1:0] rdy_ff, rdy_in;
   logic [COUNT_WIDTH-1:0] nxt_run, nxt_rdy;
   logic [TIME_WIDTH-1:0]  now;
   logic [SUM_W-1:0]       run_x, rdy_x, wk_x, busy_x;
   logic                   accept, err;

   assign accept = req_push && !q_full;
   assign now    = req_event_time[TIME_WIDTH-1:0];
   assign run_x  = SUM_W'(run_ff);
   assign rdy_x  = SUM_W'(rdy_ff);
   assign wk_x   = SUM_W'(worker_ff);
   assign busy_x = run_x + rdy_x;

   always_comb begin
      q_delay = '0;
      q_idle  = '0;
      if (run_x >= wk_x) begin
         q_delay = '0;
         q_idle  = '0;
      end else if (busy_x <= wk_x) begin
         q_delay = WORKER_W'(rdy_x);
         q_idle  = WORKER_W'(wk_x - busy_x);
      end else begin
         q_delay = WORKER_W'(wk_x - run_x);
         q_idle  = '0;
      end
   end

   always_comb begin
      nxt_run = run_ff;
      nxt_rdy = rdy_ff;
      err     = 1'b0;
      unique case (op_type'(req_operation))
         OP_READY: begin
            if (rdy_ff == '1) begin
               err = 1'b1;
            end else begin
               nxt_rdy = rdy_ff + COUNT_WIDTH'(1);
            end
         end
         OP_START: begin
            if (rdy_ff == '0) begin
               err = 1'b1;
            end else begin
               nxt_rdy = rdy_ff - COUNT_WIDTH'(1);
            end
            if (run_ff == '1) begin
               err = 1'b1;
            end else begin
               nxt_run = run_ff + COUNT_WIDTH'(1);
            end
         end
         OP_END: begin
            if (run_ff == '0) begin
               err = 1'b1;
            end else begin
               nxt_run = run_ff - COUNT_WIDTH'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      worker_in    = csr_valid ? csr_data : worker_ff;
      last_time_in = accept ? now : last_time_ff;
      run_in       = accept ? nxt_run : run_ff;
      rdy_in       = accept ? nxt_rdy : rdy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         worker_ff    <= WORKER_W'(1);
         last_time_ff <= '0;
         run_ff       <= '0;
         rdy_ff       <= '0;
      end else begin
         worker_ff    <= worker_in;
         last_time_ff <= last_time_in;
         run_ff       <= run_in;
         rdy_ff       <= rdy_in;
      end
   end

   assign q_push    = accept;
   assign q_dt      = now - last_time_ff;
   assign q_run_old = run_ff;
   assign q_run_new = nxt_run;
   assign q_rdy_new = nxt_rdy;
   assign q_over    = (run_x > wk_x);
   assign q_err     = err;

endmodule

/* design/wuac_back.sv */
// ----------------------------------------------------------------------------
// Worker utilization accounting back end
// Multiplies intervals by worker counts in halves and updates the totals.
// ----------------------------------------------------------------------------
module wuac_back #(
   parameter int COUNT_WIDTH = 16,
   parameter int TIME_WIDTH  = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   output logic                          q_pop,
   input  logic [TIME_WIDTH-1:0]         q_dt,
   input  logic [COUNT_WIDTH-1:0]        q_run_old,
   input  logic [wuac_pkg::WORKER_W-1:0] q_delay,
   input  logic [wuac_pkg::WORKER_W-1:0] q_idle,
   input  logic [COUNT_WIDTH-1:0]        q_run_new,
   input  logic [COUNT_WIDTH-1:0]        q_rdy_new,
   input  logic                          q_over,
   input  logic                          q_err,
   input  logic                          out_full,
   output logic                          out_push,
   output logic [TIME_WIDTH-1:0]         out_run_time,
   output logic [TIME_WIDTH-1:0]         out_delay_time,
   output logic [TIME_WIDTH-1:0]         out_idle_time,
   output logic [COUNT_WIDTH-1:0]        out_run_count,
   output logic [COUNT_WIDTH-1:0]        out_rdy_count,
   output logic                          out_over,
   output logic                          out_err
);
   import wuac_pkg::*;

   localparam int LO_W = TIME_WIDTH / 2;
   localparam int HI_W = TIME_WIDTH - LO_W;
   localparam int RL_W = LO_W + COUNT_WIDTH;
   localparam int RH_W = HI_W + COUNT_WIDTH;
   localparam int WL_W = LO_W + WORKER_W;
   localparam int WH_W = HI_W + WORKER_W;

   logic [LO_W-1:0] dt_lo;
   logic [HI_W-1:0] dt_hi;
   logic [RL_W-1:0] run_lo_p;
   logic [RH_W-1:0] run_hi_p;
   logic [WL_W-1:0] dly_lo_p, idl_lo_p;
   logic [WH_W-1:0] dly_hi_p, idl_hi_p;

   logic                   s1_valid_ff, s1_valid_in;
   logic [TIME_WIDTH-1:0]  s1_run_lo_ff, s1_dly_lo_ff, s1_idl_lo_ff;
   logic [HI_W-1:0]        s1_run_hi_ff, s1_dly_hi_ff, s1_idl_hi_ff;
   logic [COUNT_WIDTH-1:0] s1_run_new_ff, s1_rdy_new_ff;
   logic                   s1_over_ff, s1_err_ff;
   logic                   s1_advance;

   logic [TIME_WIDTH-1:0]  run_acc_ff, run_acc_in;
   logic [TIME_WIDTH-1:0]  dly_acc_ff, dly_acc_in;
   logic [TIME_WIDTH-1:0]  idl_acc_ff, idl_acc_in;

   assign dt_lo = q_dt[LO_W-1:0];
   assign dt_hi = q_dt[TIME_WIDTH-1:LO_W];

   assign run_lo_p = RL_W'(dt_lo) * RL_W'(q_run_old);
   assign run_hi_p = RH_W'(dt_hi) * RH_W'(q_run_old);
   assign dly_lo_p = WL_W'(dt_lo) * WL_W'(q_delay);
   assign dly_hi_p = WH_W'(dt_hi) * WH_W'(q_delay);
   assign idl_lo_p = WL_W'(dt_lo) * WL_W'(q_idle);
   assign idl_hi_p = WH_W'(dt_hi) * WH_W'(q_idle);

   assign out_push    = s1_valid_ff && !out_full;
   assign s1_advance  = !s1_valid_ff || !out_full;
   assign q_pop       = !q_empty && s1_advance;
   assign s1_valid_in = s1_advance ? !q_empty : s1_valid_ff;

   always_comb begin
      run_acc_in = run_acc_ff;
      dly_acc_in = dly_acc_ff;
      idl_acc_in = idl_acc_ff;
      if (out_push) begin
         run_acc_in = run_acc_ff + s1_run_lo_ff + (TIME_WIDTH'(s1_run_hi_ff) << LO_W);
         dly_acc_in = dly_acc_ff + s1_dly_lo_ff + (TIME_WIDTH'(s1_dly_hi_ff) << LO_W);
         idl_acc_in = idl_acc_ff + s1_idl_lo_ff + (TIME_WIDTH'(s1_idl_hi_ff) << LO_W);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         run_acc_ff  <= '0;
         dly_acc_ff  <= '0;
         idl_acc_ff  <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         run_acc_ff  <= run_acc_in;
         dly_acc_ff  <= dly_acc_in;
         idl_acc_ff  <= idl_acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_run_lo_ff  <= TIME_WIDTH'(run_lo_p);
         s1_run_hi_ff  <= HI_W'(run_hi_p);
         s1_dly_lo_ff  <= TIME_WIDTH'(dly_lo_p);
         s1_dly_hi_ff  <= HI_W'(dly_hi_p);
         s1_idl_lo_ff  <= TIME_WIDTH'(idl_lo_p);
         s1_idl_hi_ff  <= HI_W'(idl_hi_p);
         s1_run_new_ff <= q_run_new;
         s1_rdy_new_ff <= q_rdy_new;
         s1_over_ff    <= q_over;
         s1_err_ff     <= q_err;
      end
   end

   assign out_run_time   = run_acc_in;
   assign out_delay_time = dly_acc_in;
   assign out_idle_time  = idl_acc_in;
   assign out_run_count  = s1_run_new_ff;
   assign out_rdy_count  = s1_rdy_new_ff;
   assign out_over       = s1_over_ff;
   assign out_err        = s1_err_ff;

endmodule

/* design/worker_utilization_accounting_core.sv */
// ----------------------------------------------------------------------------
// Worker utilization accounting core
// Charges scheduler event intervals to running, delay and idle worker-time.
// ----------------------------------------------------------------------------
// Events enter through the req_ queue side: drive req_event_time and
// req_operation with req_push high; a transaction completes when full is low.
// Results leave through the rsp_ queue side: while rsp_empty is low the oldest
// result is on the rsp_ ports, and it completes with rsp_pop high.
// The worker count is written through csr_valid/csr_ready/csr_worker_count;
// csr_ready is always high. Writes must be made only while the block is idle;
// the block itself does not enforce it. An accepted event passes through the
// event queue, the multiplier stage register and the result queue, in that
// order. One event per cycle is sustained unless the receiver stalls; the
// front end forms new counts combinationally; the back end is fully pipelined.
// Reset clears the counts, totals and both queues and sets the worker count
// to one. When the receiver stalls, the two-entry result queue fills, then
// the multiplier stage and the two-entry event queue, and req_full rises.
// ----------------------------------------------------------------------------
`include "worker_utilization_accounting_core_assert.svh"

module worker_utilization_accounting_core #(
   parameter int COUNT_WIDTH = 16,
   parameter int TIME_WIDTH  = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [wuac_pkg::WORKER_W-1:0]      csr_worker_count,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [wuac_pkg::OUT_TIME_W-1:0]    req_event_time,
   input  logic [wuac_pkg::OP_W-1:0]          req_operation,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [wuac_pkg::OUT_TIME_W-1:0]    rsp_running_time_total,
   output logic [wuac_pkg::OUT_TIME_W-1:0]    rsp_delay_time_total,
   output logic [wuac_pkg::OUT_TIME_W-1:0]    rsp_idle_time_total,
   output logic [wuac_pkg::OUT_COUNT_W-1:0]   rsp_running_count,
   output logic [wuac_pkg::OUT_COUNT_W-1:0]   rsp_ready_count,
   output logic                               rsp_oversubscribed,
   output logic                               rsp_count_error
);
   import wuac_pkg::*;

   localparam int TW    = TIME_WIDTH;
   localparam int CW    = COUNT_WIDTH;
   localparam int MID_W = TW + 3 * CW + 2 * WORKER_W + 2;
   localparam int OUT_W = 3 * TW + 2 * CW + 2;

   logic                f_push, mid_full, mid_empty, mid_pop;
   logic [TW-1:0]       f_dt, m_dt;
   logic [CW-1:0]       f_run_old, f_run_new, f_rdy_new;
   logic [CW-1:0]       m_run_old, m_run_new, m_rdy_new;
   logic [WORKER_W-1:0] f_delay, f_idle, m_delay, m_idle;
   logic                f_over, f_err, m_over, m_err;
   logic [MID_W-1:0]    mid_wdata, mid_rdata;

   logic                out_push, out_full;
   logic [TW-1:0]       b_run_time, b_delay_time, b_idle_time;
   logic [TW-1:0]       o_run_time, o_delay_time, o_idle_time;
   logic [CW-1:0]       b_run_count, b_rdy_count, o_run_count, o_rdy_count;
   logic                b_over, b_err, o_over, o_err;
   logic [OUT_W-1:0]    out_wdata, out_rdata;

   assign csr_ready = 1'b1;
   assign req_full  = mid_full;

   wuac_front #(
      .COUNT_WIDTH (CW),
      .TIME_WIDTH  (TW)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_data       (csr_worker_count),
      .req_push       (req_push),
      .req_event_time (req_event_time),
      .req_operation  (req_operation),
      .q_full         (mid_full),
      .q_push         (f_push),
      .q_dt           (f_dt),
      .q_run_old      (f_run_old),
      .q_delay        (f_delay),
      .q_idle         (f_idle),
      .q_run_new      (f_run_new),
      .q_rdy_new      (f_rdy_new),
      .q_over         (f_over),
      .q_err          (f_err)
   );

   assign mid_wdata = {f_dt, f_run_old, f_delay, f_idle, f_run_new, f_rdy_new, f_over, f_err};
   assign {m_dt, m_run_old, m_delay, m_idle, m_run_new, m_rdy_new, m_over, m_err} = mid_rdata;

   wuac_fifo #(
      .WIDTH (MID_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_mid_queue (
      .clock (clock),
      .reset (reset),
      .push  (f_push),
      .wdata (mid_wdata),
      .full  (mid_full),
      .pop   (mid_pop),
      .rdata (mid_rdata),
      .empty (mid_empty)
   );

   wuac_back #(
      .COUNT_WIDTH (CW),
      .TIME_WIDTH  (TW)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (mid_empty),
      .q_pop          (mid_pop),
      .q_dt           (m_dt),
      .q_run_old      (m_run_old),
      .q_delay        (m_delay),
      .q_idle         (m_idle),
      .q_run_new      (m_run_new),
      .q_rdy_new      (m_rdy_new),
      .q_over         (m_over),
      .q_err          (m_err),
      .out_full       (out_full),
      .out_push       (out_push),
      .out_run_time   (b_run_time),
      .out_delay_time (b_delay_time),
      .out_idle_time  (b_idle_time),
      .out_run_count  (b_run_count),
      .out_rdy_count  (b_rdy_count),
      .out_over       (b_over),
      .out_err        (b_err)
   );

   assign out_wdata = {b_run_time, b_delay_time, b_idle_time, b_run_count, b_rdy_count,
                       b_over, b_err};
   assign {o_run_time, o_delay_time, o_idle_time, o_run_count, o_rdy_count,
           o_over, o_err} = out_rdata;

   wuac_fifo #(
      .WIDTH (OUT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_out_queue (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_wdata),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (out_rdata),
      .empty (rsp_empty)
   );

   assign rsp_running_time_total = OUT_TIME_W'(o_run_time);
   assign rsp_delay_time_total   = OUT_TIME_W'(o_delay_time);
   assign rsp_idle_time_total    = OUT_TIME_W'(o_idle_time);
   assign rsp_running_count      = OUT_COUNT_W'(o_run_count);
   assign rsp_ready_count        = OUT_COUNT_W'(o_rdy_count);
   assign rsp_oversubscribed     = o_over;
   assign rsp_count_error        = o_err;

   `WUAC_ASSERT_IMP(a_mid_pop_nonempty, clock, reset, mid_pop, !mid_empty)
   `WUAC_ASSERT_IMP(a_out_push_room, clock, reset, out_push, !out_full)
   `WUAC_ASSERT_NEXT(a_accept_queued, clock, reset, req_push && !req_full, !mid_empty)
   `WUAC_ASSERT_IMP(a_empty_after_reset, clock, reset, $fell(reset), rsp_empty && !mid_pop)

endmodule
